// File: sv/cdtgs_pkg.sv
// ----------------------------------------------------------------------------
// cdtgs_pkg
// Shared types and constants of the cumulative-table Gaussian sampler.
// ----------------------------------------------------------------------------
package cdtgs_pkg;

  localparam int ProbBits      = 48;
  localparam int ModBits       = 63;
  localparam int LenBits       = 9;
  localparam int EntryIdxBits  = 8;
  localparam int CfgIdxBits    = 2;
  localparam int CfgDataBits   = ModBits;
  localparam int SubBits       = 64;
  localparam int DefTableDepth = 256;

  localparam logic [ProbBits-1:0] ProbHalf = ProbBits'(1) << (ProbBits - 1);
  localparam logic [ModBits-1:0]  ModMax   = {ModBits{1'b1}};
  localparam logic [LenBits-1:0]  LenReset = LenBits'(256);

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CENTER_MASS  = 2'd0,
    CFG_MODULUS      = 2'd1,
    CFG_TABLE_LENGTH = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_KEY,
    ST_PROBE,
    ST_CMP,
    ST_WRAP,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e                 action;
    logic [EntryIdxBits-1:0] entry_index;
    logic [ProbBits-1:0]     entry_value;
    logic [ProbBits-1:0]     random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [ModBits-1:0] sample;
    logic               not_found;
  } out_item_t;

endpackage

// File: sv/cdt_gaussian_sampler.sv
// ----------------------------------------------------------------------------
// cdt_gaussian_sampler
// Discrete Gaussian sampler that inverts a cumulative probability table with
// a lower-bound binary search driven by one shared subtractor.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                          Moves
//  in        sink       in_valid_i, in_ready_o, in_i     load or sample item
//  out       source     out_valid_o, out_ready_i, out_o  sample result item
//  cfg       sink       cfg_we_i, cfg_idx_i, cfg_wdata_i register write
//
//  A load item is written to the table as it is accepted and yields no result item.
//  A sample item runs the magnitude and key steps, then a probe and a compare step
//  for each of the S halving steps of the search (at most ceil(log2(len+1)), 9 for
//  256 entries) and a last probe; a wrapped negative sample adds a wrap step. Each
//  halving step needs one table read followed by one compare in the shared subtractor.
//  Reset idles the sequencer, clears center mass and modulus and sets the table
//  length to 256; the table is not cleared and must be loaded before it is searched.
//  The input is not ready while an item is in work or its result waits.
//
module cdt_gaussian_sampler #(
  parameter int TABLE_DEPTH = cdtgs_pkg::DefTableDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  cdtgs_pkg::in_item_t                  in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output cdtgs_pkg::out_item_t                 out_o,
  input  logic                                 cfg_we_i,
  input  logic [cdtgs_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [cdtgs_pkg::CfgDataBits-1:0]    cfg_wdata_i
);

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int LenW = $clog2(TABLE_DEPTH + 1);
  localparam int LdW  = (IdxW + 1 > cdtgs_pkg::EntryIdxBits + 1) ?
                        IdxW + 1 : cdtgs_pkg::EntryIdxBits + 1;
  localparam int CmpW = (LenW > cdtgs_pkg::LenBits) ? LenW : cdtgs_pkg::LenBits;
  localparam int PW   = cdtgs_pkg::ProbBits;
  localparam int MW   = cdtgs_pkg::ModBits;
  localparam int SW   = cdtgs_pkg::SubBits;

  // Configuration registers.
  logic [PW-1:0]                     center_mass_q;
  logic [MW-1:0]                     modulus_q;
  logic [cdtgs_pkg::LenBits-1:0]     table_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_mass_q  <= '0;
      modulus_q      <= '0;
      table_length_q <= cdtgs_pkg::LenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cdtgs_pkg::CFG_CENTER_MASS:  center_mass_q  <= cfg_wdata_i[PW-1:0];
        cdtgs_pkg::CFG_MODULUS:      modulus_q      <= cfg_wdata_i[MW-1:0];
        cdtgs_pkg::CFG_TABLE_LENGTH: table_length_q <= cfg_wdata_i[cdtgs_pkg::LenBits-1:0];
        default: ;
      endcase
    end
  end

  cdtgs_pkg::state_e state_q, state_d;

  logic [PW-1:0]   u_q;
  logic            neg_q;
  logic [PW-1:0]   acc_q;
  logic [LenW-1:0] first_q;
  logic [LenW-1:0] count_q;
  logic [MW-1:0]   result_q;
  logic            nf_q;
  logic [PW-1:0]   mem_rdata_q;
  logic [PW-1:0]   cdf_mem [TABLE_DEPTH];

  logic            in_acc;
  logic            load_hit;
  logic [LdW-1:0]  ld_idx;
  logic [CmpW-1:0] tl_ext;
  logic [LenW-1:0] len;
  logic [LenW-1:0] step;
  logic [LenW-1:0] probe;
  logic [PW-1:0]   half_mass;
  logic [MW-1:0]   mod_eff;
  logic [SW-1:0]   sub_a, sub_b;
  logic [SW:0]     diff;
  logic            borrow;
  logic            diff_zero;

  assign in_acc    = in_valid_i && in_ready_o;
  assign ld_idx    = LdW'(in_i.entry_index);
  assign load_hit  = in_acc && (in_i.action == cdtgs_pkg::ACT_LOAD) &&
                     (ld_idx < LdW'(TABLE_DEPTH));
  assign tl_ext    = CmpW'(table_length_q);
  assign len       = (tl_ext > CmpW'(TABLE_DEPTH)) ? LenW'(TABLE_DEPTH) : LenW'(tl_ext);
  assign step      = count_q >> 1;
  assign probe     = first_q + step;
  assign half_mass = center_mass_q >> 1;
  assign mod_eff   = (modulus_q == '0) ? cdtgs_pkg::ModMax : modulus_q;

  // The one subtractor; its borrow doubles as the less-than compare.
  assign diff      = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow    = diff[SW];
  assign diff_zero = (diff[SW-1:0] == '0);

  // Table memory with registered read port.
  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      cdf_mem[ld_idx[IdxW-1:0]] <= in_i.entry_value;
    end
    mem_rdata_q <= cdf_mem[probe[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdtgs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdtgs_pkg::ST_IDLE: begin
        if (in_acc && (in_i.action == cdtgs_pkg::ACT_SAMPLE)) begin
          state_d = cdtgs_pkg::ST_MAG;
        end
      end
      cdtgs_pkg::ST_MAG: state_d = cdtgs_pkg::ST_KEY;
      cdtgs_pkg::ST_KEY: begin
        if (borrow || diff_zero) begin
          state_d = cdtgs_pkg::ST_DONE;
        end else begin
          state_d = cdtgs_pkg::ST_PROBE;
        end
      end
      cdtgs_pkg::ST_PROBE: begin
        if (count_q != '0) begin
          state_d = cdtgs_pkg::ST_CMP;
        end else if (first_q == len || !neg_q) begin
          state_d = cdtgs_pkg::ST_DONE;
        end else begin
          state_d = cdtgs_pkg::ST_WRAP;
        end
      end
      cdtgs_pkg::ST_CMP:  state_d = cdtgs_pkg::ST_PROBE;
      cdtgs_pkg::ST_WRAP: state_d = cdtgs_pkg::ST_DONE;
      cdtgs_pkg::ST_DONE: begin
        if (out_ready_i) begin
          state_d = cdtgs_pkg::ST_IDLE;
        end
      end
      default: state_d = cdtgs_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs and subtractor operand selection.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    sub_a       = '0;
    sub_b       = '0;
    unique case (state_q)
      cdtgs_pkg::ST_IDLE: in_ready_o = 1'b1;
      cdtgs_pkg::ST_MAG: begin
        sub_a = neg_q ? SW'(cdtgs_pkg::ProbHalf) : SW'(u_q);
        sub_b = neg_q ? SW'(u_q) : SW'(cdtgs_pkg::ProbHalf);
      end
      cdtgs_pkg::ST_KEY: begin
        sub_a = SW'(acc_q);
        sub_b = SW'(half_mass);
      end
      cdtgs_pkg::ST_CMP: begin
        sub_a = SW'(mem_rdata_q);
        sub_b = SW'(acc_q);
      end
      cdtgs_pkg::ST_WRAP: begin
        sub_a = SW'(mod_eff);
        sub_b = SW'(result_q);
      end
      cdtgs_pkg::ST_DONE: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      cdtgs_pkg::ST_IDLE: begin
        u_q   <= in_i.random_fraction;
        neg_q <= ~in_i.random_fraction[PW-1];
      end
      cdtgs_pkg::ST_MAG: acc_q <= diff[PW-1:0];
      cdtgs_pkg::ST_KEY: begin
        acc_q    <= diff[PW-1:0];
        first_q  <= '0;
        count_q  <= len;
        result_q <= '0;
        nf_q     <= 1'b0;
      end
      cdtgs_pkg::ST_PROBE: begin
        if (count_q == '0) begin
          if (first_q == len) begin
            nf_q     <= 1'b1;
            result_q <= '0;
          end else begin
            result_q <= MW'(first_q) + MW'(1);
          end
        end
      end
      cdtgs_pkg::ST_CMP: begin
        if (borrow) begin
          first_q <= probe + LenW'(1);
          count_q <= count_q - step - LenW'(1);
        end else begin
          count_q <= step;
        end
      end
      cdtgs_pkg::ST_WRAP: result_q <= diff[MW-1:0];
      default: ;
    endcase
  end

  assign out_o.sample    = result_q;
  assign out_o.not_found = nf_q;

  // Checks.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result item waits");

  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.not_found) |-> (out_o.sample == '0))
    else $error("not_found result carries a nonzero sample");

  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cdtgs_pkg::ST_CMP) |-> (probe < len))
    else $error("search probe outside the table in use");

  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cdtgs_pkg::ST_PROBE) |-> ((LenW + 1)'(first_q) + (LenW + 1)'(count_q)
                                          <= (LenW + 1)'(len)))
    else $error("search span runs past the table length");

  a_sample_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.action == cdtgs_pkg::ACT_SAMPLE)) |=> (state_q == cdtgs_pkg::ST_MAG))
    else $error("accepted sample item did not start the search");

endmodule

// File: sim/tb_cdt_gaussian_sampler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cdt_gaussian_sampler
// Self-checking bench for the cumulative-table Gaussian sampler. It loads a
// monotonic table and drives directed corner cases. It then runs random load
// and draw items under several register settings and idling patterns. Every
// draw is predicted in the bench and each result item is checked in order.
// ----------------------------------------------------------------------------
module tb_cdt_gaussian_sampler;

  localparam int SettleCycles  = 32;
  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles    = 300;
  localparam int PhaseCount    = 8;
  localparam int PhaseItems    = 170;
  localparam logic [cdtgs_pkg::ProbBits-1:0] ProbMax = '1;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  cdtgs_pkg::in_item_t               in_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  cdtgs_pkg::out_item_t              out_o;
  logic                              cfg_we_i;
  logic [cdtgs_pkg::CfgIdxBits-1:0]  cfg_idx_i;
  logic [cdtgs_pkg::CfgDataBits-1:0] cfg_wdata_i;

  cdt_gaussian_sampler u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Bench copy of the table and the registers.
  logic [cdtgs_pkg::ProbBits-1:0] cum_table [cdtgs_pkg::DefTableDepth];
  logic [cdtgs_pkg::ProbBits-1:0] center_mass_q;
  logic [cdtgs_pkg::ModBits-1:0]  modulus_q;
  logic [cdtgs_pkg::LenBits-1:0]  table_len_q;

  cdtgs_pkg::out_item_t expected_draws [$];
  cdtgs_pkg::out_item_t want_draw;

  int  errors, n_loads, n_draws, n_zero, n_not_found, n_wrapped, n_settings;
  int  send_idle_pct, recv_stall_pct;
  int  hold_left, quiet_cycles;
  bit  hold_req, hold_done;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [cdtgs_pkg::ProbBits-1:0] rand_prob();
    return cdtgs_pkg::ProbBits'({$urandom, $urandom});
  endfunction

  // Monotonic table: step 2^39 per index, so the top entry sits near 2^47.
  function automatic logic [cdtgs_pkg::ProbBits-1:0] ladder_entry(input int idx);
    return (cdtgs_pkg::ProbBits'(idx + 1) << 39) -
           cdtgs_pkg::ProbBits'($urandom_range(0, 1 << 20));
  endfunction

  // Predicts the result of one item; returns 1 when the item yields a result.
  function automatic bit draw_sample(input cdtgs_pkg::in_item_t item,
                                     output cdtgs_pkg::out_item_t res);
    logic [cdtgs_pkg::ProbBits-1:0] mag, half, key;
    logic [cdtgs_pkg::ModBits-1:0]  base;
    bit                             neg;
    int                             n, first, count, step, probe;
    res = '0;
    if (item.action == cdtgs_pkg::ACT_LOAD) begin
      cum_table[item.entry_index] = item.entry_value;
      n_loads++;
      return 1'b0;
    end
    n_draws++;
    neg  = item.random_fraction < cdtgs_pkg::ProbHalf;
    mag  = neg ? cdtgs_pkg::ProbHalf - item.random_fraction :
                 item.random_fraction - cdtgs_pkg::ProbHalf;
    half = center_mass_q >> 1;
    if (mag <= half) begin
      n_zero++;
      return 1'b1;
    end
    key   = mag - half;
    n     = (table_len_q > cdtgs_pkg::DefTableDepth) ? cdtgs_pkg::DefTableDepth :
                                                        int'(table_len_q);
    first = 0;
    count = n;
    while (count > 0) begin
      step  = count / 2;
      probe = first + step;
      if (cum_table[probe] < key) begin
        first = probe + 1;
        count = count - step - 1;
      end else begin
        count = step;
      end
    end
    if (first >= n) begin
      res.not_found = 1'b1;
      n_not_found++;
      return 1'b1;
    end
    res.sample = cdtgs_pkg::ModBits'(first + 1);
    if (neg) begin
      base       = (modulus_q == '0) ? cdtgs_pkg::ModMax : modulus_q;
      res.sample = base - res.sample;
      n_wrapped++;
    end
    return 1'b1;
  endfunction

  function automatic cdtgs_pkg::in_item_t make_item(
      input cdtgs_pkg::action_e act, input int idx,
      input logic [cdtgs_pkg::ProbBits-1:0] value,
      input logic [cdtgs_pkg::ProbBits-1:0] frac);
    cdtgs_pkg::in_item_t item;
    item.action          = act;
    item.entry_index     = cdtgs_pkg::EntryIdxBits'(idx);
    item.entry_value     = value;
    item.random_fraction = frac;
    return item;
  endfunction

  function automatic logic [cdtgs_pkg::ProbBits-1:0] rand_fraction();
    logic [cdtgs_pkg::ProbBits-1:0] off;
    off = rand_prob() >> $urandom_range(1, 47);
    case ($urandom_range(4))
      0, 1: return $urandom_range(1) ? cdtgs_pkg::ProbHalf + off :
                                       cdtgs_pkg::ProbHalf - off;
      2:    begin
        case ($urandom_range(4))
          0: return '0;
          1: return ProbMax;
          2: return cdtgs_pkg::ProbHalf;
          3: return cdtgs_pkg::ProbHalf + 1'b1;
          default: return cdtgs_pkg::ProbHalf - 1'b1;
        endcase
      end
      default: return rand_prob();
    endcase
  endfunction

  function automatic cdtgs_pkg::in_item_t random_item();
    int idx;
    idx = $urandom_range(cdtgs_pkg::DefTableDepth - 1);
    if ($urandom_range(99) < 15) begin
      return make_item(cdtgs_pkg::ACT_LOAD, idx,
                       ($urandom_range(19) == 0) ? rand_prob() : ladder_entry(idx),
                       rand_prob());
    end
    return make_item(cdtgs_pkg::ACT_SAMPLE, idx, rand_prob(), rand_fraction());
  endfunction

  task automatic add_expected(input cdtgs_pkg::out_item_t res);
    expected_draws = {expected_draws, res};
  endtask

  task automatic send_item(input cdtgs_pkg::in_item_t item);
    cdtgs_pkg::out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (draw_sample(item, res)) add_expected(res);
  endtask

  task automatic load_entry(input int idx, input logic [cdtgs_pkg::ProbBits-1:0] value);
    send_item(make_item(cdtgs_pkg::ACT_LOAD, idx, value, rand_prob()));
  endtask

  task automatic draw(input logic [cdtgs_pkg::ProbBits-1:0] frac);
    send_item(make_item(cdtgs_pkg::ACT_SAMPLE, $urandom_range(cdtgs_pkg::DefTableDepth - 1),
                        rand_prob(), frac));
  endtask

  // Loads take no result, so a fixed settle follows the last result item.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [cdtgs_pkg::ProbBits-1:0] cm,
                                input logic [cdtgs_pkg::ModBits-1:0] md,
                                input logic [cdtgs_pkg::LenBits-1:0] len);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= cdtgs_pkg::CFG_CENTER_MASS;
    cfg_wdata_i <= cdtgs_pkg::CfgDataBits'(cm);
    @(posedge clk_i);
    cfg_idx_i   <= cdtgs_pkg::CFG_MODULUS;
    cfg_wdata_i <= cdtgs_pkg::CfgDataBits'(md);
    @(posedge clk_i);
    cfg_idx_i   <= cdtgs_pkg::CFG_TABLE_LENGTH;
    cfg_wdata_i <= cdtgs_pkg::CfgDataBits'(len);
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    center_mass_q  = cm;
    modulus_q      = md;
    table_len_q    = len;
    n_settings++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_table_load();
    set_idling(0, 0);
    for (int i = 0; i < cdtgs_pkg::DefTableDepth; i++) load_entry(i, ladder_entry(i));
  endtask

  // Reset values: zero center mass, modulus meaning the largest value, full table.
  task automatic test_reset_settings();
    draw(cdtgs_pkg::ProbHalf);
    draw(cdtgs_pkg::ProbHalf + 1'b1);
    draw(cdtgs_pkg::ProbHalf - 1'b1);
    draw(ProbMax);
    draw('0);
  endtask

  task automatic test_corner_cases();
    load_entry(cdtgs_pkg::DefTableDepth - 1, ProbMax);
    load_entry(0, '0);
    draw('0);
    // Full center mass: only the most negative fraction leaves zero, and the
    // tiny modulus makes the negative result wrap around.
    apply_settings(ProbMax, cdtgs_pkg::ModBits'(1), cdtgs_pkg::LenBits'(256));
    draw('0);
    draw(ProbMax);
    draw(cdtgs_pkg::ProbHalf);
    apply_settings('0, cdtgs_pkg::ModMax, cdtgs_pkg::LenBits'(1));
    draw(cdtgs_pkg::ProbHalf - 1'b1);
    load_entry(0, ladder_entry(0));
    draw(cdtgs_pkg::ProbHalf - 1'b1);
    apply_settings('0, cdtgs_pkg::ModBits'(1000), cdtgs_pkg::LenBits'(0));
    draw(cdtgs_pkg::ProbHalf + cdtgs_pkg::ProbBits'(5));
    draw(cdtgs_pkg::ProbHalf);
    apply_settings(rand_prob() >> 20, cdtgs_pkg::ModBits'(1000), cdtgs_pkg::LenBits'(511));
    draw('0);
    draw(ProbMax);
    // Break the ordering of the table in a few places.
    load_entry(127, rand_prob());
    load_entry(63, rand_prob());
    load_entry(191, '0);
    repeat (3) draw(rand_fraction());
  endtask

  task automatic test_random_phases();
    logic [cdtgs_pkg::ProbBits-1:0] cm;
    logic [cdtgs_pkg::ModBits-1:0]  md;
    logic [cdtgs_pkg::LenBits-1:0]  len;
    int                             mode;
    for (int p = 0; p < PhaseCount; p++) begin
      case ($urandom_range(3))
        0:       cm = '0;
        1:       cm = ProbMax;
        default: cm = rand_prob() >> $urandom_range(4, 47);
      endcase
      case ($urandom_range(3))
        0:       md = '0;
        1:       md = cdtgs_pkg::ModMax;
        2:       md = cdtgs_pkg::ModBits'($urandom_range(1, 300));
        default: md = cdtgs_pkg::ModBits'({$urandom, $urandom});
      endcase
      case ($urandom_range(3))
        0:       len = cdtgs_pkg::LenBits'(256);
        1:       len = cdtgs_pkg::LenBits'($urandom_range(1, 256));
        2:       len = cdtgs_pkg::LenBits'($urandom_range(1, 16));
        default: len = cdtgs_pkg::LenBits'($urandom_range(0, 511));
      endcase
      apply_settings(cm, md, len);
      mode = p % 4;
      case (mode)
        0:       set_idling(0, 0);
        1:       set_idling(84, 0);
        2:       set_idling(0, 84);
        default: set_idling(7, 7);
      endcase
      repeat (PhaseItems) send_item(random_item());
    end
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_output_backpressure();
    apply_settings(rand_prob() >> 30, cdtgs_pkg::ModMax, cdtgs_pkg::LenBits'(256));
    set_idling(0, 0);
    hold_req = 1'b1;
    repeat (6) draw(rand_fraction());
  endtask

  // Receiver: random stalls, or a long hold-off counted here.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_draws.size() == 0) begin
        errors++;
        $display("%0t: result item with none expected, sample %0d not_found %0b",
                 $time, out_o.sample, out_o.not_found);
      end else begin
        want_draw = expected_draws.pop_front();
        if (out_o.sample !== want_draw.sample) begin
          errors++;
          $display("%0t: sample mismatch, expected %0d, actual %0d",
                   $time, want_draw.sample, out_o.sample);
        end
        if (out_o.not_found !== want_draw.not_found) begin
          errors++;
          $display("%0t: not_found mismatch, expected %0b, actual %0b",
                   $time, want_draw.not_found, out_o.not_found);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("tb_cdt_gaussian_sampler: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    in_i          <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= cdtgs_pkg::CFG_CENTER_MASS;
    cfg_wdata_i   <= '0;
    hold_req       = 1'b0;
    center_mass_q  = '0;
    modulus_q      = '0;
    table_len_q    = cdtgs_pkg::LenReset;
    set_idling(0, 0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_table_load();
    test_reset_settings();
    test_corner_cases();
    test_random_phases();
    test_output_backpressure();

    wait_idle();
    $display("Ran %0d loads and %0d draws over %0d register settings and four idling modes.",
             n_loads, n_draws, n_settings);
    $display("Draws: %0d zero, %0d not found, %0d negative wrapped.",
             n_zero, n_not_found, n_wrapped);
    if (errors == 0 && expected_draws.size() == 0) begin
      $display("tb_cdt_gaussian_sampler: done, clean");
    end else begin
      $display("tb_cdt_gaussian_sampler: done, errors");
    end
    $finish;
  end

endmodule
